[hw/rtl/fdm_pkg.sv]
// ----------------------------------------------------------------------------
// fdm_pkg: shared types and constants of the frame difference motion mask
// Geometry limits, register indexes, coefficient formats and the bundle that
// the coefficient unit hands to the pixel pipeline.
// ----------------------------------------------------------------------------
package fdm_pkg;

  localparam int MAX_WIDTH   = 320;
  localparam int MAX_HEIGHT  = 240;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int POS_W       = $clog2(STORE_DEPTH);
  localparam int SIZE_W      = $clog2(STORE_DEPTH + 1);

  localparam int PIXEL_W     = 8;
  localparam int CFG_DATA_W  = 9;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CONTRAST       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd4;

  localparam logic [7:0] THRESHOLD_RESET = 8'd45;
  localparam logic [8:0] WIDTH_RESET     = 9'(MAX_WIDTH);
  localparam logic [7:0] HEIGHT_RESET    = 8'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(STORE_DEPTH);
  localparam logic [POS_W-1:0]  LAST_RESET = POS_W'(STORE_DEPTH - 1);

  // gain a is unsigned Q8.16 (plus headroom), offset b is signed Q16.16
  localparam int A_W = 24;
  localparam int B_W = 33;
  localparam int K_W = 17;
  localparam int P_W = A_W + 1 + K_W;
  localparam int MAP_W = B_W + 1;

  // restoring divider for the gain
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = 16;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [15:0] CONTRAST_SPAN = 16'd16320;
  localparam logic [DIV_N_W-1:0] DIV_NUM_POS = DIV_N_W'(16320 * 131072);
  localparam logic [DIV_N_W-1:0] DIV_NUM_NEG_RND = DIV_N_W'(255);
  localparam logic [DIV_D_W-1:0] DIV_DEN_NEG = DIV_D_W'(510);

  localparam logic [A_W-1:0] A_RESET = A_W'((256 * 131072 + 255) / 510);
  localparam int B_ROUND   = 64;
  localparam int MAP_ROUND = 32768;
  localparam logic [B_W-1:0] BIAS_RESET = B_W'(MAP_ROUND);

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SETUP,
    CS_DIV,
    CS_MUL,
    CS_BIAS
  } coef_state_t;

  typedef struct packed {
    logic              busy;
    logic [7:0]        threshold;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  last_index;
    logic [A_W-1:0]    gain;
    logic [B_W-1:0]    bias;
  } coef_t;

endpackage

[hw/rtl/fdm_in_if.sv]
// ----------------------------------------------------------------------------
// fdm_in_if: pixel input channel
// Valid/ready channel that carries one grayscale pixel and its frame mark.
// ----------------------------------------------------------------------------
interface fdm_in_if;
  logic                         valid;
  logic                         ready;
  logic [fdm_pkg::PIXEL_W-1:0]  gray_pixel;
  logic                         frame_start;

  modport source (output valid, gray_pixel, frame_start, input ready);
  modport sink (input valid, gray_pixel, frame_start, output ready);
endinterface

[hw/rtl/fdm_out_if.sv]
// ----------------------------------------------------------------------------
// fdm_out_if: motion mask output channel
// Valid/ready channel that carries one mask pixel with its flags.
// ----------------------------------------------------------------------------
interface fdm_out_if;
  logic                         valid;
  logic                         ready;
  logic [fdm_pkg::PIXEL_W-1:0]  motion_pixel;
  logic                         mask_valid;
  logic                         frame_end;

  modport source (output valid, motion_pixel, mask_valid, frame_end, input ready);
  modport sink (input valid, motion_pixel, mask_valid, frame_end, output ready);
endinterface

[hw/rtl/frame_difference_motion_mask.sv]
// ----------------------------------------------------------------------------
// frame_difference_motion_mask: pixel stream motion detector
// Maps each pixel through a brightness/contrast gain, compares it with the
// same pixel of the previous frame and flags differences above threshold.
// ----------------------------------------------------------------------------
//  channel    direction  handshake        payload
//  pixel_in   in         valid / ready    gray_pixel, frame_start
//  mask_out   out        valid / ready    motion_pixel, mask_valid, frame_end
//  cfg        in         cfg_write        cfg_index, cfg_data
//
//  One pixel per cycle unless the output stalls or the coefficients update;
//  Its stages: input, gain multiply, offset add/clamp, frame store, compare.
//  The frame store is read and written in the same stage, so no forwarding.
//  After a register write the input holds off until the coefficient unit
//  is idle again; its divider makes one quotient bit per cycle.
//  Each stage advances when the one after it is free; a stalled output
//  backs up stage by stage while earlier stages keep filling bubbles.
//  Reset is synchronous; the frame store is not cleared.
// ----------------------------------------------------------------------------
module frame_difference_motion_mask (
  input  logic                                clk,
  input  logic                                rst,
  fdm_in_if.sink                              pixel_in,
  fdm_out_if.source                           mask_out,
  input  logic                                cfg_write,
  input  logic [fdm_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [fdm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int STAGES = 5;

  fdm_pkg::coef_t coef;

  fdm_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] adv;
  logic              accept;

  logic [fdm_pkg::POS_W-1:0] position;
  logic                      have_previous;
  logic [fdm_pkg::POS_W-1:0] pos_now;
  logic                      last_now;

  logic [fdm_pkg::PIXEL_W-1:0]     s1_pix;
  logic [fdm_pkg::POS_W-1:0]       s1_pos;
  logic                            s1_valid, s1_last;
  logic [fdm_pkg::A_W+7:0]         s2_prod;
  logic [fdm_pkg::POS_W-1:0]       s2_pos;
  logic                            s2_valid, s2_last;
  logic [fdm_pkg::PIXEL_W-1:0]     s3_mapped;
  logic [fdm_pkg::POS_W-1:0]       s3_pos;
  logic                            s3_valid, s3_last;
  logic [fdm_pkg::PIXEL_W-1:0]     s4_mapped, s4_old;
  logic                            s4_valid, s4_last;
  logic [fdm_pkg::PIXEL_W-1:0]     out_motion;
  logic                            out_mask_valid, out_frame_end;

  logic [fdm_pkg::PIXEL_W-1:0] frame_mem [fdm_pkg::STORE_DEPTH];

  logic signed [fdm_pkg::MAP_W-1:0] map_sum;
  logic [fdm_pkg::PIXEL_W-1:0]      map_clamp;
  logic [fdm_pkg::PIXEL_W-1:0]      diff;

  // stage i moves when it is empty or the next stage moves
  always_comb begin
    adv[STAGES-1] = !stage_valid[STAGES-1] || mask_out.ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !stage_valid[i] || adv[i+1];
    end
  end

  assign pixel_in.ready = adv[0] && !coef.busy && !cfg_write;
  assign accept         = pixel_in.valid && pixel_in.ready;

  // restart on a frame mark or when the geometry shrank to or below the position
  always_comb begin
    if (pixel_in.frame_start || (fdm_pkg::SIZE_W'(position) >= coef.size)) begin
      pos_now = '0;
    end else begin
      pos_now = position;
    end
    last_now = pos_now == coef.last_index;
  end

  always_comb begin
    map_sum = $signed({2'b00, s2_prod}) + $signed({coef.bias[fdm_pkg::B_W-1], coef.bias});
    if (map_sum[fdm_pkg::MAP_W-1]) begin
      map_clamp = '0;
    end else if (|map_sum[fdm_pkg::MAP_W-2:24]) begin
      map_clamp = '1;
    end else begin
      map_clamp = map_sum[23:16];
    end
    diff = (s4_mapped > s4_old) ? s4_mapped - s4_old : s4_old - s4_mapped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= '0;
      position      <= '0;
      have_previous <= 1'b0;
    end else begin
      if (adv[0]) begin
        stage_valid[0] <= accept;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
      if (accept) begin
        position <= last_now ? '0 : pos_now + 1'b1;
        if (last_now) begin
          have_previous <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel_in.gray_pixel;
      s1_pos   <= pos_now;
      s1_valid <= have_previous;
      s1_last  <= last_now;
    end
    if (adv[1] && stage_valid[0]) begin
      s2_prod  <= coef.gain * (fdm_pkg::A_W+8)'(s1_pix);
      s2_pos   <= s1_pos;
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
    end
    if (adv[2] && stage_valid[1]) begin
      s3_mapped <= map_clamp;
      s3_pos    <= s2_pos;
      s3_valid  <= s2_valid;
      s3_last   <= s2_last;
    end
    // read the old pixel and overwrite it in one transaction
    if (adv[3] && stage_valid[2]) begin
      s4_old            <= frame_mem[s3_pos];
      frame_mem[s3_pos] <= s3_mapped;
      s4_mapped         <= s3_mapped;
      s4_valid          <= s3_valid;
      s4_last           <= s3_last;
    end
    if (adv[4] && stage_valid[3]) begin
      out_motion     <= (s4_valid && (diff > coef.threshold)) ? '1 : '0;
      out_mask_valid <= s4_valid;
      out_frame_end  <= s4_last;
    end
  end

  assign mask_out.valid        = stage_valid[STAGES-1];
  assign mask_out.motion_pixel = out_motion;
  assign mask_out.mask_valid   = out_mask_valid;
  assign mask_out.frame_end    = out_frame_end;

endmodule

[hw/rtl/fdm_coef.sv]
// ----------------------------------------------------------------------------
// fdm_coef: configuration registers and coefficient unit
// Holds the registers and, after every write, derives the gain, the offset
// and the frame size with a bit-serial divider and multipliers.
// ----------------------------------------------------------------------------
module fdm_coef (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fdm_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [fdm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output fdm_pkg::coef_t                      coef
);

  logic [7:0] brightness;
  logic [7:0] contrast;
  logic [7:0] diff_threshold;
  logic [8:0] frame_width;
  logic [7:0] frame_height;

  fdm_pkg::coef_state_t state, state_next;
  logic busy, setup_run, div_run, mul_run, bias_run;

  logic [fdm_pkg::DIV_N_W-1:0]       div_nq;
  logic [fdm_pkg::DIV_D_W-1:0]       div_d;
  logic [fdm_pkg::DIV_D_W-1:0]       div_rem;
  logic [fdm_pkg::STEP_W-1:0]        div_step;
  logic signed [fdm_pkg::K_W-1:0]    k_r;
  logic [fdm_pkg::P_W-1:0]           addend_r;
  logic signed [fdm_pkg::P_W-1:0]    prod_b;

  logic [fdm_pkg::A_W-1:0]           gain;
  logic [fdm_pkg::B_W-1:0]           bias;
  logic [fdm_pkg::SIZE_W-1:0]        size;
  logic [fdm_pkg::POS_W-1:0]         last_index;

  logic                              contrast_pos;
  logic [13:0]                       c127;
  logic [15:0]                       den;
  logic [9:0]                        scale_neg;
  logic [8:0]                        neg_c;
  logic signed [fdm_pkg::K_W-1:0]    r128, c17, c_times, k_calc;
  logic [fdm_pkg::P_W-1:0]           addend_calc;
  logic [fdm_pkg::DIV_N_W-1:0]       num_calc;
  logic [fdm_pkg::DIV_D_W-1:0]       den_calc;
  logic [8:0]                        width_clamp;
  logic [7:0]                        height_clamp;
  logic [fdm_pkg::DIV_D_W:0]         rem_sh, rem_sub;
  logic                              rem_ge;
  logic signed [fdm_pkg::P_W-1:0]    bias_sum;

  // operands of the gain division and of the offset product, and the clamped geometry
  always_comb begin
    contrast_pos = !contrast[7] && (contrast != 8'd0);
    c127         = 14'(contrast[6:0]) * 14'd127;
    den          = fdm_pkg::CONTRAST_SPAN - 16'(c127);
    scale_neg    = 10'd256 + {contrast[7], contrast, 1'b0};
    neg_c        = 9'd0 - {contrast[7], contrast};
    r128         = $signed({{2{brightness[7]}}, brightness, 7'd0});
    c17          = $signed({{9{contrast[7]}}, contrast});
    c_times      = c17 * 17'sd127;
    if (contrast_pos) begin
      num_calc    = fdm_pkg::DIV_NUM_POS + fdm_pkg::DIV_N_W'(den);
      den_calc    = {den[fdm_pkg::DIV_D_W-2:0], 1'b0};
      k_calc      = r128 - c_times;
      addend_calc = fdm_pkg::P_W'(fdm_pkg::B_ROUND);
    end else begin
      num_calc    = fdm_pkg::DIV_N_W'({scale_neg[8:0], 17'd0}) + fdm_pkg::DIV_NUM_NEG_RND;
      den_calc    = fdm_pkg::DIV_DEN_NEG;
      k_calc      = r128;
      addend_calc = fdm_pkg::P_W'({neg_c, 23'd0}) + fdm_pkg::P_W'(fdm_pkg::B_ROUND);
    end
    if (frame_width == 9'd0) begin
      width_clamp = 9'd1;
    end else if (frame_width > 9'(fdm_pkg::MAX_WIDTH)) begin
      width_clamp = 9'(fdm_pkg::MAX_WIDTH);
    end else begin
      width_clamp = frame_width;
    end
    if (frame_height == 8'd0) begin
      height_clamp = 8'd1;
    end else if (frame_height > 8'(fdm_pkg::MAX_HEIGHT)) begin
      height_clamp = 8'(fdm_pkg::MAX_HEIGHT);
    end else begin
      height_clamp = frame_height;
    end
  end

  always_comb begin
    rem_sh   = {div_rem, div_nq[fdm_pkg::DIV_N_W-1]};
    rem_ge   = rem_sh >= {1'b0, div_d};
    rem_sub  = rem_sh - {1'b0, div_d};
    bias_sum = prod_b + $signed(addend_r);
  end

  // next state: any write restarts the sequence
  always_comb begin
    state_next = state;
    case (state)
      fdm_pkg::CS_IDLE:  state_next = fdm_pkg::CS_IDLE;
      fdm_pkg::CS_SETUP: state_next = fdm_pkg::CS_DIV;
      fdm_pkg::CS_DIV: begin
        if (div_step == fdm_pkg::STEP_W'(fdm_pkg::DIV_STEPS - 1)) begin
          state_next = fdm_pkg::CS_MUL;
        end
      end
      fdm_pkg::CS_MUL:   state_next = fdm_pkg::CS_BIAS;
      fdm_pkg::CS_BIAS:  state_next = fdm_pkg::CS_IDLE;
      default:           state_next = fdm_pkg::CS_IDLE;
    endcase
    if (cfg_write) begin
      state_next = fdm_pkg::CS_SETUP;
    end
  end

  always_comb begin
    busy      = 1'b1;
    setup_run = 1'b0;
    div_run   = 1'b0;
    mul_run   = 1'b0;
    bias_run  = 1'b0;
    case (state)
      fdm_pkg::CS_IDLE:  busy      = 1'b0;
      fdm_pkg::CS_SETUP: setup_run = 1'b1;
      fdm_pkg::CS_DIV:   div_run   = 1'b1;
      fdm_pkg::CS_MUL:   mul_run   = 1'b1;
      fdm_pkg::CS_BIAS:  bias_run  = 1'b1;
      default:           busy      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness     <= 8'd0;
      contrast       <= 8'd0;
      diff_threshold <= fdm_pkg::THRESHOLD_RESET;
      frame_width    <= fdm_pkg::WIDTH_RESET;
      frame_height   <= fdm_pkg::HEIGHT_RESET;
      state          <= fdm_pkg::CS_IDLE;
      gain           <= fdm_pkg::A_RESET;
      bias           <= fdm_pkg::BIAS_RESET;
      size           <= fdm_pkg::SIZE_RESET;
      last_index     <= fdm_pkg::LAST_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fdm_pkg::REG_BRIGHTNESS:     brightness     <= cfg_data[7:0];
          fdm_pkg::REG_CONTRAST:       contrast       <= cfg_data[7:0];
          fdm_pkg::REG_DIFF_THRESHOLD: diff_threshold <= cfg_data[7:0];
          fdm_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data[8:0];
          fdm_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data[7:0];
          default: ;
        endcase
      end
      state <= state_next;
      if (setup_run) begin
        size <= fdm_pkg::SIZE_W'(17'(width_clamp) * 17'(height_clamp));
      end
      if (mul_run) begin
        last_index <= fdm_pkg::POS_W'(size - 1'b1);
      end
      if (bias_run) begin
        gain <= div_nq[fdm_pkg::A_W-1:0];
        bias <= bias_sum[fdm_pkg::B_W+6:7] + fdm_pkg::B_W'(fdm_pkg::MAP_ROUND);
      end
    end
  end

  // divider and offset datapath, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (setup_run) begin
      div_nq   <= num_calc;
      div_d    <= den_calc;
      div_rem  <= '0;
      div_step <= '0;
      k_r      <= k_calc;
      addend_r <= addend_calc;
    end
    if (div_run) begin
      div_rem  <= rem_ge ? rem_sub[fdm_pkg::DIV_D_W-1:0] : rem_sh[fdm_pkg::DIV_D_W-1:0];
      div_nq   <= {div_nq[fdm_pkg::DIV_N_W-2:0], rem_ge};
      div_step <= div_step + 1'b1;
    end
    if (mul_run) begin
      prod_b <= $signed({1'b0, div_nq[fdm_pkg::A_W-1:0]}) * k_r;
    end
  end

  always_comb begin
    coef.busy       = busy;
    coef.threshold  = diff_threshold;
    coef.size       = size;
    coef.last_index = last_index;
    coef.gain       = gain;
    coef.bias       = bias;
  end

endmodule

[hw/rtl/fdm_checker.sv]
// ----------------------------------------------------------------------------
// fdm_checker: port-level checks of the motion mask block
// Watches the channels and the configuration port of the top level.
// ----------------------------------------------------------------------------
module fdm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fdm_pkg::PIXEL_W-1:0]   motion_pixel,
  input logic                          mask_valid,
  input logic                          frame_end,
  input logic                          cfg_write
);

  logic seen_end;

  // note when a frame has fully left the block
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_end <= 1'b0;
    end else if (out_valid && out_ready && frame_end) begin
      seen_end <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motion_pixel)
      && $stable(mask_valid) && $stable(frame_end))
    else $error("stalled output transaction changed");

  a_mask_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motion_pixel == 8'h00 || motion_pixel == 8'hFF)
    else $error("motion pixel is neither 0 nor 255");

  a_invalid_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mask_valid |-> motion_pixel == 8'h00)
    else $error("motion reported without a previous frame");

  a_valid_after_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && mask_valid |-> seen_end)
    else $error("mask valid before any frame ended");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> !in_ready ##1 !in_ready)
    else $error("input taken while coefficients update");

endmodule

bind frame_difference_motion_mask fdm_checker u_fdm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pixel_in.ready),
  .out_valid    (mask_out.valid),
  .out_ready    (mask_out.ready),
  .motion_pixel (mask_out.motion_pixel),
  .mask_valid   (mask_out.mask_valid),
  .frame_end    (mask_out.frame_end),
  .cfg_write    (cfg_write)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: frame difference motion mask testbench
// Streams grayscale frames through the block under random valid/ready
// pressure and checks every mask transaction against a scripted word or a
// local predictor of the tone map, the frame store and the frame position
// logic. A short scripted part covers reset state, clamped geometry,
// threshold and contrast extremes, unmarked and early frame starts and a
// geometry shrink mid-frame. Random phases then retune the registers and
// replay mostly well-formed frames with pixels close to the stored ones.
// ----------------------------------------------------------------------------
module tb;
  import fdm_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int DRAIN_LIMIT = 20000;
  localparam int REPORT_LIMIT = 10;
  localparam int SCRIPT_LEN = 28;

  typedef struct packed {
    logic [7:0] motion;
    logic       mvalid;
    logic       fend;
  } mask_word_t;

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_REG,
    ROW_FILL
  } row_kind_t;

  // value is register data for ROW_REG and a pixel count for ROW_FILL
  typedef struct packed {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
    logic [7:0]            gray;
    logic                  start;
    logic                  typed;
    logic [7:0]            motion;
    logic                  mvalid;
    logic                  fend;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fdm_in_if  pixel_ch ();
  fdm_out_if mask_ch ();

  frame_difference_motion_mask uut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_ch),
    .mask_out  (mask_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] brightness_q;
  logic [7:0] contrast_q;
  logic [7:0] threshold_q;
  logic [8:0] width_q;
  logic [7:0] height_q;
  int         frame_pos;
  logic       have_prev_frame;
  bit [7:0]   stored_map [STORE_DEPTH];
  bit [7:0]   stored_gray [STORE_DEPTH];

  mask_word_t pending_masks [$];
  int         error_count;
  int         items_sent;
  logic       calm;

  //  kind    index            value   gray   st typed motion mv fe
  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd0,   1'b1, 1'b1, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd255, 1'b0, 1'b1, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_FRAME_WIDTH,    9'd511, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_FRAME_HEIGHT,   9'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_FILL,  REG_BRIGHTNESS,     9'd317, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0, 1'b1},
    '{ROW_REG,   REG_FRAME_WIDTH,    9'd3,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_FRAME_HEIGHT,   9'd1,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd255, 1'b0, 1'b1, 8'd255, 1'b1, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd0,   1'b0, 1'b1, 8'd255, 1'b1, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd100, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_DIFF_THRESHOLD, 9'd255, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd0,   1'b1, 1'b1, 8'd0,   1'b1, 1'b0},
    '{ROW_REG,   REG_DIFF_THRESHOLD, 9'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_CONTRAST,       9'h080, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd255, 1'b0, 1'b1, 8'd255, 1'b1, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd7,   1'b1, 1'b1, 8'd255, 1'b1, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd200, 1'b0, 1'b1, 8'd0,   1'b1, 1'b0},
    '{ROW_REG,   REG_FRAME_WIDTH,    9'd2,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_BRIGHTNESS,     9'h07F, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_CONTRAST,       9'h07F, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_BRIGHTNESS,     9'h080, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_CONTRAST,       9'h081, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd255, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_PIXEL, REG_BRIGHTNESS,     9'd0,   8'd128, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
    '{ROW_REG,   REG_DIFF_THRESHOLD, 9'd45,  8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 1'b0}
  };

  // round to nearest, ties toward plus infinity, d > 0
  function automatic longint round_div(longint x, longint d);
    longint y;
    y = x + d / 2;
    return (y >= 0) ? y / d : -((-y + d - 1) / d);
  endfunction

  function automatic logic [7:0] tone_map(logic [7:0] gray);
    longint r, c, den, a, b, v;
    r = longint'($signed(brightness_q));
    c = longint'($signed(contrast_q));
    if (c > 0) begin
      den = 16320 - 127 * c;
      a = (longint'(16320) * 65536 * 2 + den) / (2 * den);
      b = round_div(a * (128 * r - 127 * c), 128);
    end else begin
      a = ((256 + 2 * c) * 65536 * 2 + 255) / 510;
      b = a * r + (-c) * 65536;
    end
    v = round_div(a * longint'(gray) + b, 65536);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic int frame_area();
    int w, h;
    w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q));
    h = (height_q == 0) ? 1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q));
    return w * h;
  endfunction

  function automatic mask_word_t predict_mask(logic [7:0] gray, logic start);
    mask_word_t res;
    int area, pos;
    logic [7:0] mapped, old, diff;
    area = frame_area();
    if (start || frame_pos >= area) frame_pos = 0;
    pos = frame_pos;
    mapped = tone_map(gray);
    old = stored_map[pos];
    diff = (mapped > old) ? mapped - old : old - mapped;
    res.mvalid = have_prev_frame;
    res.motion = (have_prev_frame && diff > threshold_q) ? 8'hFF : 8'h00;
    res.fend = (pos == area - 1);
    stored_map[pos] = mapped;
    stored_gray[pos] = gray;
    if (res.fend) begin
      have_prev_frame = 1'b1;
      frame_pos = 0;
    end else begin
      frame_pos = pos + 1;
    end
    return res;
  endfunction

  // mostly replay the stored pixel or a near copy so both mask values occur
  function automatic logic [7:0] pick_gray(logic start);
    int pos, k, v;
    pos = (start || frame_pos >= frame_area()) ? 0 : frame_pos;
    k = $urandom_range(99);
    if (k < 40) return stored_gray[pos];
    if (k < 65) begin
      v = int'(stored_gray[pos]) + int'($urandom_range(40)) - 20;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    end
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h81;
      3: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] gray, input logic start,
                            input logic typed, input mask_word_t want);
    mask_word_t pred;
    if (!calm && $urandom_range(99) < 15) begin
      pixel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.gray_pixel <= gray;
    pixel_ch.frame_start <= start;
    do @(posedge clk); while (!pixel_ch.ready);
    pred = predict_mask(gray, start);
    pending_masks.push_back(typed ? want : pred);
    items_sent++;
    calm <= (items_sent >= 500 && items_sent < 650);
  endtask

  // write only with the pipeline empty
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    pixel_ch.valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BRIGHTNESS:     brightness_q = val[7:0];
      REG_CONTRAST:       contrast_q = val[7:0];
      REG_DIFF_THRESHOLD: threshold_q = val[7:0];
      REG_FRAME_WIDTH:    width_q = val;
      REG_FRAME_HEIGHT:   height_q = val[7:0];
      default: ;
    endcase
  endtask

  // Frame sizes stay within the 320 entries filled by the scripted first
  // frame, so no unwritten store entry is ever compared.
  task automatic retune();
    int k;
    logic [8:0] w;
    logic [7:0] h;
    if ($urandom_range(1)) write_reg(REG_BRIGHTNESS, {1'b0, pick_level()});
    if ($urandom_range(1)) write_reg(REG_CONTRAST, {1'b0, pick_level()});
    if ($urandom_range(2) == 0) begin
      if ($urandom_range(1)) write_reg(REG_DIFF_THRESHOLD, 9'($urandom_range(60)));
      else write_reg(REG_DIFF_THRESHOLD, {1'b0, 8'($urandom)});
    end
    if ($urandom_range(1)) begin
      k = $urandom_range(99);
      if (k < 2) begin
        w = 9'd511;
        h = 8'd1;
      end else if (k < 4) begin
        w = 9'd1;
        h = 8'd255;
      end else if (k < 6) begin
        w = 9'd17;
        h = 8'd18;
      end else begin
        w = 9'($urandom_range(9));
        h = 8'($urandom_range(4));
      end
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, {1'b0, h});
    end
  endtask

  always @(posedge clk) begin
    if (calm) mask_ch.ready <= 1'b1;
    else mask_ch.ready <= ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin : check_masks
    mask_word_t want;
    if (!rst && mask_ch.valid && mask_ch.ready) begin
      if (pending_masks.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected mask: motion %0d valid %0b end %0b",
                   mask_ch.motion_pixel, mask_ch.mask_valid, mask_ch.frame_end);
      end else begin
        want = pending_masks.pop_front();
        if (mask_ch.motion_pixel !== want.motion || mask_ch.mask_valid !== want.mvalid ||
            mask_ch.frame_end !== want.fend) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mask mismatch: expected motion %0d valid %0b end %0b, got %0d %0b %0b",
                     want.motion, want.mvalid, want.fend, mask_ch.motion_pixel,
                     mask_ch.mask_valid, mask_ch.frame_end);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int i, n, frames, shape, len, goal, guard;
    logic mark, noisy, st;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_BRIGHTNESS;
    cfg_data = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.gray_pixel = '0;
    pixel_ch.frame_start = 1'b0;
    mask_ch.ready = 1'b0;
    calm = 1'b0;
    error_count = 0;
    items_sent = 0;
    brightness_q = 8'd0;
    contrast_q = 8'd0;
    threshold_q = THRESHOLD_RESET;
    width_q = WIDTH_RESET;
    height_q = HEIGHT_RESET;
    frame_pos = 0;
    have_prev_frame = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < SCRIPT_LEN; i++) begin
      case (script[i].kind)
        ROW_REG: write_reg(script[i].index, script[i].value);
        ROW_FILL: begin
          repeat (script[i].value) send_pixel(8'($urandom), 1'b0, 1'b0, '0);
        end
        default: begin
          send_pixel(script[i].gray, script[i].start, script[i].typed,
                     '{script[i].motion, script[i].mvalid, script[i].fend});
        end
      endcase
    end

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      retune();
      frames = (frame_area() > 64) ? 1 : $urandom_range(1, 4);
      repeat (frames) begin
        shape = $urandom_range(99);
        noisy = 1'b0;
        mark = 1'b1;
        if (shape < 75) begin
          len = frame_area();
          mark = ($urandom_range(3) != 0);
        end else if (shape < 90) begin
          // cut short: random length, so the next marked frame start may arrive early
          len = $urandom_range(1, frame_area());
        end else begin
          len = $urandom_range(1, 8);
          noisy = 1'b1;
          mark = $urandom_range(1);
        end
        for (n = 0; n < len; n++) begin
          st = (n == 0) ? mark : (noisy && $urandom_range(7) == 0);
          send_pixel(pick_gray(st), st, 1'b0, '0);
        end
      end
    end

    pixel_ch.valid <= 1'b0;
    guard = 0;
    while (pending_masks.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_masks.size() != 0)
      $display("%0d expected masks never arrived", pending_masks.size());
    error_count += pending_masks.size();
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/fdm_pkg.sv
hw/rtl/fdm_in_if.sv
hw/rtl/fdm_out_if.sv
hw/rtl/fdm_coef.sv
hw/rtl/frame_difference_motion_mask.sv
hw/rtl/fdm_checker.sv
verif/tb.sv
